/* hdl/mpeg_audio_header_parser_top_macros.svh */
// ----------------------------------------------------------------------------
// MPEG audio header parser assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MPEG_AUDIO_HEADER_PARSER_TOP_MACROS_SVH
`define MPEG_AUDIO_HEADER_PARSER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MAHP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MAHP_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/mahp_pkg.sv */
// ----------------------------------------------------------------------------
// MPEG audio header parser package
// Field widths, header codes, rate tables and reciprocal constants.
// ----------------------------------------------------------------------------
package mahp_pkg;

   localparam int unsigned HDR_W   = 32;
   localparam int unsigned BPS_W   = 19;
   localparam int unsigned HZ_W    = 16;
   localparam int unsigned BYTES_W = 12;
   localparam int unsigned KBPS_W  = 9;
   localparam int unsigned PROD_W  = 17;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned CSR_IDX_LSB = 2;

   localparam logic        CSR_MINIMAL_MODE = 1'b0;
   localparam logic [10:0] SYNC_PATTERN     = 11'h7FF;

   typedef enum logic [1:0] {
      VER_MPEG25   = 2'd0,
      VER_RESERVED = 2'd1,
      VER_MPEG2    = 2'd2,
      VER_MPEG1    = 2'd3
   } mpeg_version_type;

   localparam logic [1:0] LAYER_NONE = 2'd0;
   localparam logic [1:0] LAYER_I    = 2'd1;
   localparam logic [1:0] LAYER_III  = 2'd3;
   localparam logic [1:0] MODE_JOINT = 2'd1;

   localparam logic [1:0] RIDX_44K = 2'd0;
   localparam logic [1:0] RIDX_48K = 2'd1;
   localparam logic [1:0] RIDX_32K = 2'd2;

   localparam logic [7:0] COEF_L1   = 8'd12;
   localparam logic [7:0] COEF_HALF = 8'd72;
   localparam logic [7:0] COEF_FULL = 8'd144;
   localparam logic [9:0] KBPS_SCALE = 10'd1000;

   // floor(n * 10 / 441) == (n * 12173950) >> 29 for n below 2^17.
   localparam logic [23:0] RECIP_441X10 = 24'd12173950;
   localparam int unsigned SHIFT_441    = 29;
   localparam int unsigned PROD441_W    = PROD_W + 24;
   // floor(x / 3) == (x * 10923) >> 15 for x below 2^13.
   localparam logic [13:0] RECIP_3   = 14'd10923;
   localparam int unsigned SHIFT_3   = 15;
   localparam int unsigned PROD3_W   = PROD_W - 4 + 14;

   localparam logic [KBPS_W-1:0] KBPS_TABLE [5][16] = '{
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
   };

   // MPEG-1 sample rate for a rate index; the other versions divide it by 2 or 4.
   function automatic logic [HZ_W-1:0] rate_base(input logic [1:0] ridx);
      logic [HZ_W-1:0] hz;
      case (ridx)
         RIDX_44K: hz = 16'd44100;
         RIDX_48K: hz = 16'd48000;
         RIDX_32K: hz = 16'd32000;
         default:  hz = '0;
      endcase
      return hz;
   endfunction

   typedef struct packed {
      logic                header_ok;
      logic [1:0]          version_code;
      logic [1:0]          layer_number;
      logic [BPS_W-1:0]    bitrate_bps;
      logic [HZ_W-1:0]     sample_rate_hz;
      logic [1:0]          channel_mode;
      logic [BYTES_W-1:0]  frame_bytes;
      logic                padded;
      logic [4:0]          intensity_band;
      logic [1:0]          stereo_ext_flags;
      logic [3:0]          misc_flags;
      logic [1:0]          emphasis;
   } rsp_type;

   // Fields that ride along the pipe unchanged after decode.
   typedef struct packed {
      logic                ok;
      logic [1:0]          ver;
      logic [1:0]          layer_num;
      logic [1:0]          ridx;
      logic [HZ_W-1:0]     hz;
      logic [1:0]          mode;
      logic                pad;
      logic [4:0]          band;
      logic [1:0]          sflags;
      logic [3:0]          misc;
      logic [1:0]          emph;
   } side_type;

   typedef struct packed {
      side_type            side;
      logic [KBPS_W-1:0]   kbps;
      logic [7:0]          coef;
      logic [1:0]          shift;
   } s1_type;

   typedef struct packed {
      side_type            side;
      logic [PROD_W-1:0]   n;
      logic [BPS_W-1:0]    bps;
   } s2_type;

   typedef struct packed {
      side_type            side;
      logic [BYTES_W-1:0]  quot;
      logic [BPS_W-1:0]    bps;
   } s3_type;

endpackage

/* hdl/mahp_req_if.sv */
// ----------------------------------------------------------------------------
// MPEG audio header parser request channel
// Valid/ready channel carrying one 32-bit frame header word.
// ----------------------------------------------------------------------------
interface mahp_req_if;
   import mahp_pkg::*;

   logic             valid;
   logic             ready;
   logic [HDR_W-1:0] header_word;

   modport source (output valid, output header_word, input ready);
   modport sink   (input valid, input header_word, output ready);
endinterface

/* hdl/mahp_rsp_if.sv */
// ----------------------------------------------------------------------------
// MPEG audio header parser response channel
// Valid/ready channel carrying the decoded header fields.
// ----------------------------------------------------------------------------
interface mahp_rsp_if;
   import mahp_pkg::*;

   logic               valid;
   logic               ready;
   logic               header_ok;
   logic [1:0]         version_code;
   logic [1:0]         layer_number;
   logic [BPS_W-1:0]   bitrate_bps;
   logic [HZ_W-1:0]    sample_rate_hz;
   logic [1:0]         channel_mode;
   logic [BYTES_W-1:0] frame_bytes;
   logic               padded;
   logic [4:0]         intensity_band;
   logic [1:0]         stereo_ext_flags;
   logic [3:0]         misc_flags;
   logic [1:0]         emphasis;

   modport source (output valid, output header_ok, output version_code,
                   output layer_number, output bitrate_bps, output sample_rate_hz,
                   output channel_mode, output frame_bytes, output padded,
                   output intensity_band, output stereo_ext_flags, output misc_flags,
                   output emphasis, input ready);
   modport sink   (input valid, input header_ok, input version_code,
                   input layer_number, input bitrate_bps, input sample_rate_hz,
                   input channel_mode, input frame_bytes, input padded,
                   input intensity_band, input stereo_ext_flags, input misc_flags,
                   input emphasis, output ready);
endinterface

/* hdl/mpeg_audio_header_parser_top.sv */
// ----------------------------------------------------------------------------
// MPEG audio frame header parser
// Four-stage pipeline that checks a frame header word and decodes its fields.
// ----------------------------------------------------------------------------
// Usage:
//   A request on req_ch carries one 32-bit header word, first stream byte in
//   bits 31..24. Each request yields exactly one response on rsp_ch, in order.
//   A rejected header gives header_ok low and every other field zero.
//   A new request is taken every cycle while rsp_ch.ready stays high. Each
//   request passes through four register stages, the first loaded at the
//   accepting edge: decode and table lookup, bit-rate products, reciprocal
//   multiply for the sample-rate division, and the output register with
//   padding applied.
//   Each stage has its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles close up and requests keep flowing while
//   a response waits. When the receiver holds rsp_ch.ready low the pipe fills
//   and then req_ch.ready drops; nothing is lost or repeated.
//   Reset clears all valid bits and sets minimal_mode to 1. The register sits
//   at csr address 0 and is read back there; write it only while idle.
// ----------------------------------------------------------------------------
`include "mpeg_audio_header_parser_top_macros.svh"

module mpeg_audio_header_parser_top (
   input  logic                              clock,
   input  logic                              reset,
   mahp_req_if.sink                          req_ch,
   mahp_rsp_if.source                        rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mahp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [mahp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [mahp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import mahp_pkg::*;

   logic minimal_mode_ff, minimal_mode_in;

   logic    v1_ff, v2_ff, v3_ff, v4_ff;
   logic    rdy1, rdy2, rdy3, rdy4;
   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in;
   rsp_type out_ff, out_in;

   // ---------------- configuration port ----------------
   logic csr_write;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      minimal_mode_in = minimal_mode_ff;
      if (csr_write && csr_paddr[CSR_IDX_LSB] == CSR_MINIMAL_MODE) begin
         minimal_mode_in = csr_pwdata[0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_IDX_LSB] == CSR_MINIMAL_MODE) begin
         csr_prdata = {{(CSR_DATA_W-1){1'b0}}, minimal_mode_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         minimal_mode_ff <= 1'b1;
      end else begin
         minimal_mode_ff <= minimal_mode_in;
      end
   end

   // ---------------- flow control ----------------
   assign rdy4 = !v4_ff || rsp_ch.ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_ch.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_ch.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // ---------------- stage 1: decode and lookup ----------------
   logic [HDR_W-1:0]  w;
   logic [1:0]        ver, lay, ridx, layer_num, ext;
   logic [3:0]        bidx;
   logic [2:0]        row;
   logic [KBPS_W-1:0] kbps;
   logic [HZ_W-1:0]   base_hz;

   always_comb begin
      w         = req_ch.header_word;
      ver       = w[20:19];
      lay       = w[18:17];
      bidx      = w[15:12];
      ridx      = w[11:10];
      ext       = w[5:4];
      layer_num = 2'd0 - lay;
      if (ver == VER_MPEG1) begin
         row = {1'b0, layer_num - 2'd1};
      end else if (layer_num == LAYER_I) begin
         row = 3'd3;
      end else begin
         row = 3'd4;
      end
      kbps    = KBPS_TABLE[row][bidx];
      base_hz = rate_base(ridx);

      s1_in.kbps = kbps;
      case (ver)
         VER_MPEG1: s1_in.shift = 2'd0;
         VER_MPEG2: s1_in.shift = 2'd1;
         default:   s1_in.shift = 2'd2;
      endcase
      if (layer_num == LAYER_I) begin
         s1_in.coef = COEF_L1;
      end else if (layer_num == LAYER_III && ver != VER_MPEG1) begin
         s1_in.coef = COEF_HALF;
      end else begin
         s1_in.coef = COEF_FULL;
      end

      s1_in.side.ok = (w[31:21] == SYNC_PATTERN) && (ver != VER_RESERVED) &&
                      (lay != 2'd0) && (kbps != '0) && (base_hz != '0);
      s1_in.side.ver       = ver;
      s1_in.side.layer_num = layer_num;
      s1_in.side.ridx      = ridx;
      s1_in.side.hz        = base_hz >> s1_in.shift;
      s1_in.side.mode      = w[7:6];
      s1_in.side.pad       = w[9];
      s1_in.side.band      = '0;
      s1_in.side.sflags    = '0;
      s1_in.side.misc      = '0;
      s1_in.side.emph      = '0;
      if (!minimal_mode_ff) begin
         if (w[7:6] == MODE_JOINT) begin
            if (layer_num == LAYER_III) begin
               s1_in.side.sflags = ext;
            end else begin
               s1_in.side.band = ({3'b000, ext} + 5'd1) << 2;
            end
         end
         s1_in.side.misc = {~w[16], w[8], w[3], w[2]};
         s1_in.side.emph = w[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) s1_ff <= s1_in;
   end

   // ---------------- stage 2: products ----------------
   logic [PROD_W-1:0]  coef_prod;
   logic [PROD_W+1:0]  n_wide;

   always_comb begin
      coef_prod   = PROD_W'(s1_ff.coef) * PROD_W'(s1_ff.kbps);
      n_wide      = {2'b00, coef_prod} << s1_ff.shift;
      s2_in.side  = s1_ff.side;
      s2_in.n     = n_wide[PROD_W-1:0];
      s2_in.bps   = BPS_W'(s1_ff.kbps) * BPS_W'(KBPS_SCALE);
   end

   always_ff @(posedge clock) begin
      if (rdy2) s2_ff <= s2_in;
   end

   // ---------------- stage 3: division by the sample rate ----------------
   // The MPEG-1 rate divides n; the version shift is already folded into n.
   logic [PROD441_W-1:0] prod441;
   logic [PROD3_W-1:0]   prod3;

   always_comb begin
      prod441    = PROD441_W'(s2_ff.n) * PROD441_W'(RECIP_441X10);
      prod3      = PROD3_W'(s2_ff.n[PROD_W-1:4]) * PROD3_W'(RECIP_3);
      s3_in.side = s2_ff.side;
      s3_in.bps  = s2_ff.bps;
      case (s2_ff.side.ridx)
         RIDX_44K: s3_in.quot = prod441[SHIFT_441 +: BYTES_W];
         RIDX_48K: s3_in.quot = prod3[SHIFT_3 +: BYTES_W];
         RIDX_32K: s3_in.quot = s2_ff.n[5 +: BYTES_W];
         default:  s3_in.quot = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy3) s3_ff <= s3_in;
   end

   // ---------------- stage 4: output register ----------------
   logic [BYTES_W-1:0] slots;

   always_comb begin
      slots  = s3_ff.quot + BYTES_W'(s3_ff.side.pad);
      out_in = '0;
      if (s3_ff.side.ok) begin
         out_in.header_ok        = 1'b1;
         out_in.version_code     = s3_ff.side.ver;
         out_in.layer_number     = s3_ff.side.layer_num;
         out_in.bitrate_bps      = s3_ff.bps;
         out_in.sample_rate_hz   = s3_ff.side.hz;
         out_in.channel_mode     = s3_ff.side.mode;
         out_in.padded           = s3_ff.side.pad;
         out_in.intensity_band   = s3_ff.side.band;
         out_in.stereo_ext_flags = s3_ff.side.sflags;
         out_in.misc_flags       = s3_ff.side.misc;
         out_in.emphasis         = s3_ff.side.emph;
         // Layer I counts four-byte slots.
         if (s3_ff.side.layer_num == LAYER_I) begin
            out_in.frame_bytes = {slots[BYTES_W-3:0], 2'b00};
         end else begin
            out_in.frame_bytes = slots;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) out_ff <= out_in;
   end

   assign rsp_ch.valid            = v4_ff;
   assign rsp_ch.header_ok        = out_ff.header_ok;
   assign rsp_ch.version_code     = out_ff.version_code;
   assign rsp_ch.layer_number     = out_ff.layer_number;
   assign rsp_ch.bitrate_bps      = out_ff.bitrate_bps;
   assign rsp_ch.sample_rate_hz   = out_ff.sample_rate_hz;
   assign rsp_ch.channel_mode     = out_ff.channel_mode;
   assign rsp_ch.frame_bytes      = out_ff.frame_bytes;
   assign rsp_ch.padded           = out_ff.padded;
   assign rsp_ch.intensity_band   = out_ff.intensity_band;
   assign rsp_ch.stereo_ext_flags = out_ff.stereo_ext_flags;
   assign rsp_ch.misc_flags       = out_ff.misc_flags;
   assign rsp_ch.emphasis         = out_ff.emphasis;

   // ---------------- assertions ----------------
   `MAHP_ASSERT_IMP(a_reject_zero, rsp_ch.valid && !rsp_ch.header_ok,
      rsp_ch.frame_bytes == '0 && rsp_ch.bitrate_bps == '0 &&
      rsp_ch.sample_rate_hz == '0 && rsp_ch.layer_number == LAYER_NONE,
      "rejected header carries nonzero fields")
   `MAHP_ASSERT_IMP(a_ok_decoded, rsp_ch.valid && rsp_ch.header_ok,
      rsp_ch.frame_bytes != '0 && rsp_ch.layer_number != LAYER_NONE &&
      rsp_ch.sample_rate_hz != '0,
      "accepted header has an empty frame length, layer or rate")
   `MAHP_ASSERT_IMP(a_layer1_slots,
      rsp_ch.valid && rsp_ch.header_ok && rsp_ch.layer_number == LAYER_I,
      rsp_ch.frame_bytes[1:0] == 2'b00,
      "layer I frame length is not a whole number of slots")
   `MAHP_ASSERT_IMP(a_full_backpressure,
      v1_ff && v2_ff && v3_ff && v4_ff && !rsp_ch.ready,
      !req_ch.ready,
      "full pipe stalled by the receiver still takes a request")
   `MAHP_ASSERT_NXT(a_enter_stage1, req_ch.valid && req_ch.ready, v1_ff,
      "accepted request did not reach the first stage")

endmodule

/* tb/mpeg_audio_header_parser_top_test.sv */
// ----------------------------------------------------------------------------
// MPEG audio header parser testbench
// Sends frame header words through the request channel and compares every
// decoded response, field by field, with fields typed into the case table or
// with a behavioral decode of the same word. A short table of hand-picked
// headers comes first, then random headers that are mostly well formed, under
// three pacing profiles and both settings of the minimal-mode register.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mpeg_audio_header_parser_top_test;
   import mahp_pkg::*;

   localparam int unsigned RANDOM_PER_PHASE = 576;
   localparam int unsigned DRAIN_CYCLES     = 8;
   localparam int unsigned LIMIT_CYCLES     = 200000;
   localparam int unsigned REPORT_LIMIT     = 10;

   localparam logic [CSR_ADDR_W-1:0] MINIMAL_MODE_ADDR =
      CSR_ADDR_W'(CSR_MINIMAL_MODE) << CSR_IDX_LSB;
   // The next register slot holds nothing; writes to it must be ignored.
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR =
      MINIMAL_MODE_ADDR + CSR_ADDR_W'(1 << CSR_IDX_LSB);

   localparam logic [1:0] LAYER_BITS_RESERVED = 2'd0;
   localparam logic [1:0] LAYER_II            = 2'd2;
   localparam logic [3:0] BIDX_FREE           = 4'd0;
   localparam logic [3:0] BIDX_BAD            = 4'd15;
   localparam logic [1:0] RIDX_RESERVED       = 2'd3;
   localparam logic [1:0] MODE_STEREO         = 2'd0;
   localparam logic [1:0] MODE_MONO           = 2'd3;

   // Bit rates in kbit/s: MPEG-1 layers I, II, III, then MPEG-2/2.5 layer I,
   // then MPEG-2/2.5 layers II and III.
   localparam int unsigned KBPS_ROWS [5][16] = '{
      '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
      '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
      '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
   };

   typedef struct packed {
      logic             minimal;
      logic [HDR_W-1:0] word;
      logic             typed;
      rsp_type          fields;
   } header_case_type;

   localparam rsp_type REJECTED = '0;

   localparam int unsigned CASE_COUNT = 23;
   localparam header_case_type HEADER_CASES [CASE_COUNT] = '{
      // Register still at its reset value: optional fields read as zero.
      '{1'b1, 32'hFFFB9000, 1'b1, '{1'b1, VER_MPEG1, LAYER_III, 19'd128000,
         16'd44100, MODE_STEREO, 12'd417, 1'b0, 5'd0, 2'd0, 4'd0, 2'd0}},
      '{1'b1, 32'hFFFFEAC0, 1'b1, '{1'b1, VER_MPEG1, LAYER_I, 19'd448000,
         16'd32000, MODE_MONO, 12'd676, 1'b1, 5'd0, 2'd0, 4'd0, 2'd0}},
      '{1'b1, 32'hFFE4EA7F, 1'b1, '{1'b1, VER_MPEG25, LAYER_II, 19'd160000,
         16'd8000, MODE_JOINT, 12'd2881, 1'b1, 5'd0, 2'd0, 4'd0, 2'd0}},
      '{1'b1, 32'h00000000, 1'b1, REJECTED},
      '{1'b1, 32'hFFFFFFFF, 1'b1, REJECTED},
      // Full decode from here on.
      '{1'b0, 32'hFFE4EA7F, 1'b0, REJECTED},
      '{1'b0, 32'hFFDB9000, 1'b1, REJECTED},
      '{1'b0, 32'hFFEB9000, 1'b1, REJECTED},
      '{1'b0, 32'hFFF99000, 1'b1, REJECTED},
      '{1'b0, 32'hFFFB0000, 1'b1, REJECTED},
      '{1'b0, 32'hFFFBF000, 1'b1, REJECTED},
      '{1'b0, 32'hFFFB9C00, 1'b1, REJECTED},
      '{1'b0, 32'hFFF38776, 1'b0, REJECTED},
      '{1'b0, 32'hFFE31855, 1'b0, REJECTED},
      '{1'b0, 32'hFFF7E26A, 1'b0, REJECTED},
      '{1'b0, 32'hFFFC1440, 1'b0, REJECTED},
      '{1'b0, 32'hFFFE185C, 1'b0, REJECTED},
      '{1'b0, 32'hFFFEA060, 1'b0, REJECTED},
      '{1'b0, 32'hFFFB91B2, 1'b0, REJECTED},
      '{1'b0, 32'hFFFBE460, 1'b0, REJECTED},
      '{1'b0, 32'hFFFB1AC0, 1'b0, REJECTED},
      '{1'b0, 32'hFFF5E420, 1'b0, REJECTED},
      '{1'b0, 32'h7FFB9000, 1'b1, REJECTED}
   };

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   mahp_req_if req_ch ();
   mahp_rsp_if rsp_ch ();

   mpeg_audio_header_parser_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   rsp_type     decoded_q [$];
   logic        minimal_setting;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned cycle_count;
   int unsigned error_count;
   int unsigned requests_sent;
   int unsigned responses_seen;
   int unsigned headers_accepted;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type decode_header(input logic [HDR_W-1:0] w, input logic minimal);
      rsp_type          r;
      mpeg_version_type ver;
      int unsigned      layer;
      int unsigned      row;
      int unsigned      bps;
      int unsigned      hz;
      int unsigned      bytes;
      r   = '0;
      ver = mpeg_version_type'(w[20:19]);
      if (w[31:21] != SYNC_PATTERN || ver == VER_RESERVED || w[18:17] == LAYER_BITS_RESERVED)
         return r;
      layer = 4 - w[18:17];
      if (ver == VER_MPEG1)
         row = layer - 1;
      else
         row = (layer == 1) ? 3 : 4;
      bps = KBPS_ROWS[row][w[15:12]] * 1000;
      case (w[11:10])
         RIDX_44K: hz = 44100;
         RIDX_48K: hz = 48000;
         RIDX_32K: hz = 32000;
         default:  hz = 0;
      endcase
      // MPEG-2 halves the MPEG-1 rates and MPEG-2.5 quarters them.
      if (ver == VER_MPEG2)
         hz = hz / 2;
      else if (ver == VER_MPEG25)
         hz = hz / 4;
      if (bps == 0 || hz == 0)
         return r;
      if (layer == 1)
         bytes = (12 * bps / hz + w[9]) * 4;
      else if (layer == 3 && ver != VER_MPEG1)
         bytes = 72 * bps / hz + w[9];
      else
         bytes = 144 * bps / hz + w[9];
      r.header_ok      = 1'b1;
      r.version_code   = ver;
      r.layer_number   = 2'(layer);
      r.bitrate_bps    = BPS_W'(bps);
      r.sample_rate_hz = HZ_W'(hz);
      r.channel_mode   = w[7:6];
      r.frame_bytes    = BYTES_W'(bytes);
      r.padded         = w[9];
      if (!minimal) begin
         if (w[7:6] == MODE_JOINT) begin
            if (layer == 3)
               r.stereo_ext_flags = w[5:4];
            else
               r.intensity_band = 5'(4 * (int'(w[5:4]) + 1));
         end
         r.misc_flags = {~w[16], w[8], w[3], w[2]};
         r.emphasis   = w[1:0];
      end
      return r;
   endfunction

   // Mostly well-formed headers with random content; some have one field
   // broken, and the rest are plain noise.
   function automatic logic [HDR_W-1:0] random_header();
      logic [HDR_W-1:0] w;
      int unsigned      pick;
      w    = $urandom();
      pick = $urandom_range(99);
      if (pick < 95) begin
         w[31:21] = SYNC_PATTERN;
         case ($urandom_range(2))
            0:       w[20:19] = VER_MPEG25;
            1:       w[20:19] = VER_MPEG2;
            default: w[20:19] = VER_MPEG1;
         endcase
         w[18:17] = 2'($urandom_range(3, 1));
         w[15:12] = 4'($urandom_range(14, 1));
         w[11:10] = 2'($urandom_range(2));
      end
      if (pick >= 80 && pick < 95) begin
         case ($urandom_range(4))
            0:       w[21 + $urandom_range(10)] = 1'b0;
            1:       w[20:19] = VER_RESERVED;
            2:       w[18:17] = LAYER_BITS_RESERVED;
            3:       w[15:12] = $urandom_range(1) ? BIDX_BAD : BIDX_FREE;
            default: w[11:10] = RIDX_RESERVED;
         endcase
      end
      return w;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   // with valid still high.
   task automatic send_header(input logic [HDR_W-1:0] word, input rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid       <= 1'b0;
         req_ch.header_word <= $urandom();
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.header_word <= word;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      decoded_q.push_back(want);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do
         @(negedge clock);
      while (decoded_q.size() != 0);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == MINIMAL_MODE_ADDR)
         minimal_setting = data[0];
   endtask

   task automatic send_random_headers(input int unsigned count);
      logic [HDR_W-1:0] word;
      for (int unsigned i = 0; i < count; i++) begin
         word = random_header();
         send_header(word, decode_header(word, minimal_setting));
      end
   endtask

   task automatic note_mismatch(input string what, input longint unsigned want,
                                input longint unsigned got);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("cycle %0d: %s expected %0d, got %0d", cycle_count, what, want, got);
   endtask

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : response_check
      rsp_type want;
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("run stopped after %0d cycles with %0d responses outstanding",
                  cycle_count, decoded_q.size());
         $display("== FAIL ==");
         $finish;
      end else if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         responses_seen++;
         if (decoded_q.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("cycle %0d: response with no request outstanding", cycle_count);
         end else begin
            want = decoded_q.pop_front();
            if (rsp_ch.header_ok) headers_accepted++;
            if (rsp_ch.header_ok !== want.header_ok)
               note_mismatch("header_ok", want.header_ok, rsp_ch.header_ok);
            if (rsp_ch.version_code !== want.version_code)
               note_mismatch("version_code", want.version_code, rsp_ch.version_code);
            if (rsp_ch.layer_number !== want.layer_number)
               note_mismatch("layer_number", want.layer_number, rsp_ch.layer_number);
            if (rsp_ch.bitrate_bps !== want.bitrate_bps)
               note_mismatch("bitrate_bps", want.bitrate_bps, rsp_ch.bitrate_bps);
            if (rsp_ch.sample_rate_hz !== want.sample_rate_hz)
               note_mismatch("sample_rate_hz", want.sample_rate_hz, rsp_ch.sample_rate_hz);
            if (rsp_ch.channel_mode !== want.channel_mode)
               note_mismatch("channel_mode", want.channel_mode, rsp_ch.channel_mode);
            if (rsp_ch.frame_bytes !== want.frame_bytes)
               note_mismatch("frame_bytes", want.frame_bytes, rsp_ch.frame_bytes);
            if (rsp_ch.padded !== want.padded)
               note_mismatch("padded", want.padded, rsp_ch.padded);
            if (rsp_ch.intensity_band !== want.intensity_band)
               note_mismatch("intensity_band", want.intensity_band, rsp_ch.intensity_band);
            if (rsp_ch.stereo_ext_flags !== want.stereo_ext_flags)
               note_mismatch("stereo_ext_flags", want.stereo_ext_flags, rsp_ch.stereo_ext_flags);
            if (rsp_ch.misc_flags !== want.misc_flags)
               note_mismatch("misc_flags", want.misc_flags, rsp_ch.misc_flags);
            if (rsp_ch.emphasis !== want.emphasis)
               note_mismatch("emphasis", want.emphasis, rsp_ch.emphasis);
         end
      end
   end

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.header_word = '0;
      rsp_ch.ready       = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      minimal_setting    = 1'b1;
      send_idle_pct      = 31;
      recv_idle_pct      = 59;
      cycle_count        = 0;
      error_count        = 0;
      requests_sent      = 0;
      responses_seen     = 0;
      headers_accepted   = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (HEADER_CASES[i]) begin
         if (HEADER_CASES[i].minimal != minimal_setting) begin
            wait_idle();
            write_csr(MINIMAL_MODE_ADDR, {{(CSR_DATA_W-1){1'b0}}, HEADER_CASES[i].minimal});
         end
         send_header(HEADER_CASES[i].word, HEADER_CASES[i].typed ? HEADER_CASES[i].fields :
                     decode_header(HEADER_CASES[i].word, minimal_setting));
      end

      // Only bit 0 of a register write counts.
      wait_idle();
      write_csr(MINIMAL_MODE_ADDR, 32'hFFFF_FFFF);
      send_random_headers(RANDOM_PER_PHASE);

      wait_idle();
      send_idle_pct = 59;
      recv_idle_pct = 31;
      write_csr(MINIMAL_MODE_ADDR, 32'hFFFF_FFFE);
      @(negedge clock);
      write_csr(UNMAPPED_ADDR, 32'h0000_0001);
      send_random_headers(RANDOM_PER_PHASE);

      wait_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(MINIMAL_MODE_ADDR, 32'h0000_0001);
      send_random_headers(RANDOM_PER_PHASE);

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d header words and checked %0d responses (%0d valid, %0d rejected).",
               requests_sent, responses_seen, headers_accepted,
               responses_seen - headers_accepted);
      $display("Both minimal-mode settings were used under three pacing profiles; %0d errors.",
               error_count);
      if (error_count == 0 && decoded_q.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/mahp_pkg.sv
hdl/mahp_req_if.sv
hdl/mahp_rsp_if.sv
hdl/mpeg_audio_header_parser_top.sv
tb/mpeg_audio_header_parser_top_test.sv
